@@ hdl/laplacian_zero_crossing_edges_defines.svh @@
// assertion macros for the laplacian zero-crossing edge block
// included by the rtl files that carry concurrent checks, no other dependencies
`ifndef LAPLACIAN_ZERO_CROSSING_EDGES_DEFINES_SVH
`define LAPLACIAN_ZERO_CROSSING_EDGES_DEFINES_SVH

// same-cycle implication, checks off while reset is asserted
`define LZCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checks off while reset is asserted
`define LZCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lzce_pkg.sv @@
// shared constants and types for the laplacian zero-crossing edge block
// no dependencies
`default_nettype none

package lzce_pkg;

    // field and register widths
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int THRESH_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OUT_TDATA_BITS = 8;

    // parameter defaults and limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 16;
    localparam int HEIGHT_LIMIT   = 4096;

    // register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = '0;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE_THRESHOLD = 2'd2;

    // word kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // line buffer strobes
    typedef struct packed {
        logic rd_en;
        logic shift;
        logic wr_en;
    } t_lb_ctrl;

    // which neighbours of the judged pixel lie inside the image
    typedef struct packed {
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
    } t_nbr_flags;

endpackage

`default_nettype wire

@@ hdl/laplacian_zero_crossing_edges.sv @@
// top level of the laplacian zero-crossing edge marker
// uses lzce_pkg, lzce_line_buf, lzce_judge and the assertion macro header
//
// usage:
//   input stream: one word per pixel in raster order, tdata carries the signed
//   laplacian value, tuser selects pixel (0) or flush tick (1). a pixel of row
//   y+1 releases the result for the pixel above it; after the last row, one
//   flush tick per column releases the last row. row 0 gives no result.
//   output stream: tdata bit 0 is the edge flag, tlast marks the frame's final
//   pixel. words that release nothing (row 0, early flush, pixel past the last
//   row) are consumed without output.
//   configuration: plain write port, index 0 width, 1 height, 2 threshold;
//   width and height writes restart the frame.
// timing:
//   a word is processed in run when the result register is free, its result
//   registered in the output register; one word per cycle is sustained while
//   the output is not stalled, set by the single line buffer read and write
//   port per column. after reset and after a width or height write the line
//   buffer window is reloaded (prime0, prime1), during which words are buffered
//   but not processed. a stalled output holds its word; one input word waits in
//   the input register and tready drops until the output drains.
`default_nettype none

`include "laplacian_zero_crossing_edges_defines.svh"

module laplacian_zero_crossing_edges #(
    parameter int MAX_WIDTH  = lzce_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = lzce_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // lap_value, zero pad
    input  logic                                   s_axis_tuser,  // op
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [lzce_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,  // edge_res, zero pad
    output logic                                   m_axis_tlast,  // frame_end
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [lzce_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [lzce_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int CW = lzce_pkg::WIDTH_BITS;
    localparam int HW = lzce_pkg::HEIGHT_BITS;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = 2 * VALUE_BITS;

    // window reload sequencer
    typedef enum logic [2:0] {
        ST_PRIME0 = 3'b001,
        ST_PRIME1 = 3'b010,
        ST_RUN    = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [CW-1:0]                    r_image_width;
    logic [HW-1:0]                    r_image_height;
    logic [lzce_pkg::THRESH_BITS-1:0] r_slope_threshold;

    // frame position
    logic [CW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;
    logic [CW-1:0] r_flush, n_flush;

    // input register
    logic                  r_s1_valid;
    logic                  r_s1_op;
    logic [VALUE_BITS-1:0] r_s1_value;

    // result register
    logic r_out_valid;
    logic r_out_edge;
    logic r_out_last;

    logic [VALUE_BITS-1:0] r_left;

    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          size_write;
    logic          out_free;
    logic          advance;
    logic          is_pix;
    logic          pix_ok;
    logic          fl_ok;
    logic          step;
    logic          emit;
    logic [CW-1:0] x;
    logic [CW:0]   x_inc;
    logic [CW:0]   x_two;
    logic [CW:0]   a2;
    logic          last_col;

    lzce_pkg::t_nbr_flags nbr;
    lzce_pkg::t_lb_ctrl   lb_ctrl;
    logic [AW-1:0]        lb_rd_addr;
    logic [AW-1:0]        lb_wr_addr;
    logic [EW-1:0]        lb_wr_data;
    logic [EW-1:0]        lb_cur;
    logic [EW-1:0]        lb_nxt;
    logic [VALUE_BITS-1:0] center;
    logic [VALUE_BITS-1:0] up;
    logic [VALUE_BITS-1:0] right;
    logic                  edge_flag;

    // out-of-range sizes clamp
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
    end

    always_comb begin
        if (r_image_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_image_height) > lzce_pkg::HEIGHT_LIMIT) begin
            h_eff = HW'(lzce_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_image_height;
        end
    end

    assign size_write = i_cfg_we && ((i_cfg_index == lzce_pkg::REG_IMAGE_WIDTH) ||
                                     (i_cfg_index == lzce_pkg::REG_IMAGE_HEIGHT));

    // handshake: the input register moves on when the result register is free, in run
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_s1_valid && out_free && (r_state == ST_RUN);
    assign s_axis_tready = !r_s1_valid || advance;

    // decode of the buffered word
    assign is_pix = (r_s1_op == lzce_pkg::OP_PIXEL);
    assign pix_ok = is_pix && (r_row < h_eff) && (r_col < w_eff);
    assign fl_ok  = !is_pix && (r_row >= h_eff) && (r_flush < w_eff);
    assign step   = advance && (pix_ok || fl_ok);
    assign emit   = pix_ok ? (r_row != '0) : fl_ok;

    // column being judged, pixels and flush ticks walk the same columns
    assign x        = is_pix ? r_col : r_flush;
    assign x_inc    = {1'b0, x} + (CW + 1)'(1);
    assign x_two    = {1'b0, x} + (CW + 1)'(2);
    assign last_col = (x_inc >= {1'b0, w_eff});

    // prefetch two columns ahead, wrapping into the next row
    always_comb begin
        if (w_eff == CW'(1)) begin
            a2 = '0;
        end else if (x_two >= {1'b0, w_eff}) begin
            a2 = x_two - {1'b0, w_eff};
        end else begin
            a2 = x_two;
        end
    end

    assign nbr.has_left  = (x != '0);
    assign nbr.has_right = !last_col;
    assign nbr.has_down  = is_pix;
    assign nbr.has_up    = is_pix ? (r_row >= HW'(2)) : (h_eff >= HW'(2));

    assign center = lb_cur[VALUE_BITS-1:0];
    assign up     = lb_cur[EW-1:VALUE_BITS];
    assign right  = lb_nxt[VALUE_BITS-1:0];

    // line buffer control: reload reads column 0 then column 1, a step reads ahead
    always_comb begin
        lb_ctrl    = '0;
        lb_rd_addr = '0;
        unique case (r_state)
            ST_PRIME0: begin
                lb_ctrl.rd_en = 1'b1;
                lb_rd_addr    = '0;
            end
            ST_PRIME1: begin
                lb_ctrl.rd_en = 1'b1;
                lb_ctrl.shift = 1'b1;
                lb_rd_addr    = (w_eff == CW'(1)) ? AW'(0) : AW'(1);
            end
            ST_RUN: begin
                lb_ctrl.rd_en = step;
                lb_ctrl.shift = step;
                lb_ctrl.wr_en = step;
                lb_rd_addr    = AW'(a2);
            end
            default: begin
                lb_ctrl    = '0;
                lb_rd_addr = '0;
            end
        endcase
    end

    // row being judged moves up, the new pixel (or itself on flush) takes its place
    assign lb_wr_addr = AW'(x);
    assign lb_wr_data = {center, (is_pix ? r_s1_value : center)};

    lzce_line_buf #(
        .DEPTH      (MAX_WIDTH),
        .ADDR_BITS  (AW),
        .ENTRY_BITS (EW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_ctrl    (lb_ctrl),
        .i_rd_addr (lb_rd_addr),
        .i_wr_addr (lb_wr_addr),
        .i_wr_data (lb_wr_data),
        .o_cur     (lb_cur),
        .o_nxt     (lb_nxt)
    );

    lzce_judge #(
        .VALUE_BITS (VALUE_BITS)
    ) u_judge (
        .i_center    (center),
        .i_up        (up),
        .i_left      (r_left),
        .i_right     (right),
        .i_down      (r_s1_value),
        .i_nbr       (nbr),
        .i_threshold (r_slope_threshold),
        .o_edge      (edge_flag)
    );

    // sequencer and counters
    always_comb begin
        unique case (r_state)
            ST_PRIME0: n_state = ST_PRIME1;
            ST_PRIME1: n_state = ST_RUN;
            ST_RUN:    n_state = ST_RUN;
            default:   n_state = ST_PRIME0;
        endcase
        if (size_write) begin
            n_state = ST_PRIME0;
        end
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (step) begin
            if (is_pix) begin
                if (last_col) begin
                    n_col = '0;
                    n_row = r_row + HW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end else begin
                if (last_col) begin
                    n_flush = '0;
                    n_col   = '0;
                    n_row   = '0;
                end else begin
                    n_flush = r_flush + CW'(1);
                end
            end
        end
        if (size_write) begin
            n_col   = '0;
            n_row   = '0;
            n_flush = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PRIME0;
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= lzce_pkg::WIDTH_RESET;
            r_image_height    <= lzce_pkg::HEIGHT_RESET;
            r_slope_threshold <= lzce_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lzce_pkg::REG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[CW-1:0];
                lzce_pkg::REG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[HW-1:0];
                lzce_pkg::REG_SLOPE_THRESHOLD: r_slope_threshold <= i_cfg_data;
                default: begin
                    // unused index, write is dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_op    <= s_axis_tuser;
            r_s1_value <= s_axis_tdata[VALUE_BITS-1:0];
        end
    end

    // left neighbour is the center of the previous column
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_left <= center;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_edge <= edge_flag;
            r_out_last <= fl_ok && last_col;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(lzce_pkg::OUT_TDATA_BITS - 1){1'b0}}, r_out_edge};
    assign m_axis_tlast  = r_out_last;

    // checks
    `LZCE_ASSERT_IMP(a_col_in_row, i_clk, i_rst_n, r_row < h_eff, r_col < w_eff, "column count past row width")
    `LZCE_ASSERT_IMP(a_flush_idle, i_clk, i_rst_n, r_row < h_eff, r_flush == '0, "flush count moved before last row")
    `LZCE_ASSERT_IMP(a_out_from_step, i_clk, i_rst_n, $rose(r_out_valid), $past(advance), "result appeared without a processed word")
    `LZCE_ASSERT_NXT(a_frame_wrap, i_clk, i_rst_n, step && !is_pix && last_col, (r_row == '0) && (r_col == '0) && (r_flush == '0), "frame did not restart after final flush")

endmodule

`default_nettype wire

@@ hdl/lzce_line_buf.sv @@
// line buffer: one entry per column holding {row above, row being judged}
// uses lzce_pkg for the strobe struct
`default_nettype none

module lzce_line_buf #(
    parameter int DEPTH      = lzce_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_BITS  = $clog2(lzce_pkg::MAX_WIDTH_DEF),
    parameter int ENTRY_BITS = 2 * lzce_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  lzce_pkg::t_lb_ctrl    i_ctrl,
    input  logic [ADDR_BITS-1:0]  i_rd_addr,
    input  logic [ADDR_BITS-1:0]  i_wr_addr,
    input  logic [ENTRY_BITS-1:0] i_wr_data,
    output logic [ENTRY_BITS-1:0] o_cur,
    output logic [ENTRY_BITS-1:0] o_nxt
);

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;
    logic [ENTRY_BITS-1:0] r_byp_data;
    logic [ENTRY_BITS-1:0] r_win;
    logic [ADDR_BITS-1:0]  r_rd_addr;
    logic                  r_byp;
    logic [ENTRY_BITS-1:0] rd_eff;
    logic [ENTRY_BITS-1:0] n_win;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a read that hits the entry written in the same cycle takes the new data
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_byp      <= i_ctrl.wr_en && (i_rd_addr == i_wr_addr);
            r_byp_data <= i_wr_data;
            r_rd_addr  <= i_rd_addr;
        end
    end

    assign rd_eff = r_byp ? r_byp_data : r_rd_data;

    always_comb begin
        if (i_ctrl.wr_en && (r_rd_addr == i_wr_addr)) begin
            n_win = i_wr_data;
        end else begin
            n_win = rd_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= n_win;
        end
    end

    assign o_cur = r_win;
    assign o_nxt = rd_eff;

endmodule

`default_nettype wire

@@ hdl/lzce_judge.sv @@
// zero-crossing decision for one pixel from its neighbourhood
// uses lzce_pkg for the neighbour flags and threshold width
`default_nettype none

module lzce_judge #(
    parameter int VALUE_BITS = lzce_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]            i_center,
    input  logic [VALUE_BITS-1:0]            i_up,
    input  logic [VALUE_BITS-1:0]            i_left,
    input  logic [VALUE_BITS-1:0]            i_right,
    input  logic [VALUE_BITS-1:0]            i_down,
    input  lzce_pkg::t_nbr_flags             i_nbr,
    input  logic [lzce_pkg::THRESH_BITS-1:0] i_threshold,
    output logic                             o_edge
);

    localparam int SUM_BITS = VALUE_BITS + 1;
    localparam int CMP_BITS = (SUM_BITS > lzce_pkg::THRESH_BITS) ? SUM_BITS
                                                                 : lzce_pkg::THRESH_BITS;

    function automatic logic [VALUE_BITS-1:0] mag(input logic [VALUE_BITS-1:0] v);
        return v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;
    endfunction

    function automatic logic crossing(input logic [VALUE_BITS-1:0] a,
                                      input logic [VALUE_BITS-1:0] b,
                                      input logic [CMP_BITS-1:0]   thr);
        logic [CMP_BITS-1:0] sum;
        sum = CMP_BITS'(mag(a)) + CMP_BITS'(mag(b));
        return (a[VALUE_BITS-1] ^ b[VALUE_BITS-1]) && (sum > thr);
    endfunction

    logic                  nonzero;
    logic [VALUE_BITS-1:0] h_a;
    logic [VALUE_BITS-1:0] v_a;
    logic                  h_en;
    logic                  v_en;
    logic [CMP_BITS-1:0]   thr;

    // nonzero center pairs with right and down, a zero center uses its opposite sides
    assign nonzero = (i_center != '0);
    assign h_a     = nonzero ? i_center : i_left;
    assign v_a     = nonzero ? i_center : i_up;
    assign h_en    = nonzero ? i_nbr.has_right : (i_nbr.has_left && i_nbr.has_right);
    assign v_en    = nonzero ? i_nbr.has_down  : (i_nbr.has_up && i_nbr.has_down);
    assign thr     = CMP_BITS'(i_threshold);

    assign o_edge = (h_en && crossing(h_a, i_right, thr)) ||
                    (v_en && crossing(v_a, i_down, thr));

endmodule

`default_nettype wire

@@ tb/sv/laplacian_zero_crossing_edges_tb.sv @@
// self-checking bench for the laplacian zero-crossing edge marker
// drives pixel and flush words, predicts every edge word in a line-store model
// depends on lzce_pkg and the laplacian_zero_crossing_edges top level
`default_nettype none

module laplacian_zero_crossing_edges_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAP_BITS = lzce_pkg::VALUE_BITS_DEF;

    // one input word as the stream carries it
    typedef struct {
        logic                op;
        logic [LAP_BITS-1:0] lap_value;
    } t_lap_word;

    // one output word as the stream should carry it
    typedef struct {
        logic edge_res;
        logic frame_end;
    } t_edge_verdict;

    // clock, reset and dut ports, all known from time zero
    logic                                    i_clk         = 1'b0;
    logic                                    i_rst_n       = 1'b0;
    logic                                    s_axis_tvalid = 1'b0;
    logic                                    s_axis_tready;
    logic [LAP_BITS-1:0]                     s_axis_tdata  = '0;    // lap_value
    logic                                    s_axis_tuser  = 1'b0;  // op
    logic                                    m_axis_tvalid;
    logic                                    m_axis_tready = 1'b0;
    logic [lzce_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata;          // edge_res, zero pad
    logic                                    m_axis_tlast;          // frame_end
    logic                                    i_cfg_we      = 1'b0;
    logic [lzce_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index   = '0;
    logic [lzce_pkg::CFG_DATA_BITS-1:0]      i_cfg_data    = '0;

    // words waiting for the driver, verdicts waiting for the dut
    t_lap_word     lap_words[$];
    t_edge_verdict pending_verdicts[$];
    int            words_outstanding = 0;
    int            mismatch_count    = 0;
    int unsigned   random_words      = 0;
    // when set, neither side inserts idle cycles
    bit            steady            = 1'b0;

    // model of the block: register copies, frame position and the two line stores
    logic [lzce_pkg::WIDTH_BITS-1:0]  width_reg  = lzce_pkg::WIDTH_RESET;
    logic [lzce_pkg::HEIGHT_BITS-1:0] height_reg = lzce_pkg::HEIGHT_RESET;
    logic [lzce_pkg::THRESH_BITS-1:0] thresh_reg = lzce_pkg::THRESH_RESET;
    int unsigned                      col_pos    = 0;
    int unsigned                      row_pos    = 0;
    int unsigned                      flush_pos  = 0;
    // line_judged holds the row being decided, line_above the row over it;
    // while column x is handled, line_above[x-1] is the left neighbor and
    // line_judged[x+1] the right neighbor of the judged pixel
    int                               line_above  [lzce_pkg::MAX_WIDTH_DEF];
    int                               line_judged [lzce_pkg::MAX_WIDTH_DEF];

    laplacian_zero_crossing_edges i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // edge prediction
    // ------------------------------------------------------------------

    // zero and too-large sizes fold back into the legal range
    function automatic int unsigned clamp_size(int unsigned raw, int unsigned top);
        if (raw == 0) return 1;
        if (raw > top) return top;
        return raw;
    endfunction

    function automatic int unsigned eff_w();
        return clamp_size(width_reg, lzce_pkg::MAX_WIDTH_DEF);
    endfunction

    function automatic int unsigned eff_h();
        return clamp_size(height_reg, lzce_pkg::HEIGHT_LIMIT);
    endfunction

    // signs differ (zero counts as positive) and the magnitude sum beats the threshold
    function automatic bit is_crossing(int a, int b);
        int mag_a;
        int mag_b;
        mag_a = (a < 0) ? -a : a;
        mag_b = (b < 0) ? -b : b;
        return ((a < 0) != (b < 0)) && (mag_a + mag_b > int'(thresh_reg));
    endfunction

    function automatic bit judge_pixel(int unsigned x, int unsigned y, int unsigned w,
                                       bit has_down, int down);
        bit has_left;
        bit has_right;
        bit has_up;
        int mid;
        int up;
        int left;
        int right;
        has_left  = (x >= 1);
        has_right = (x + 1 < w);
        has_up    = (y >= 1);
        mid       = line_judged[x];
        up        = line_above[x];
        left      = has_left ? line_above[x - 1] : 0;
        right     = has_right ? line_judged[x + 1] : 0;
        // nonzero pixel pairs with its right and down neighbors
        if (mid != 0)
            return (has_right && is_crossing(mid, right)) ||
                   (has_down && is_crossing(mid, down));
        // zero pixel: left against right, up against down, inside the image only
        return (has_left && has_right && is_crossing(left, right)) ||
               (has_up && has_down && is_crossing(up, down));
    endfunction

    // advance the model by one accepted word and queue any verdict it releases
    function automatic void mark_edges(logic op, logic [LAP_BITS-1:0] raw);
        int unsigned   w;
        int unsigned   h;
        int unsigned   x;
        int            lap;
        t_edge_verdict v;
        w   = eff_w();
        h   = eff_h();
        lap = $signed(raw);
        if (op == lzce_pkg::OP_PIXEL) begin
            // pixel while the last row waits for flushing is dropped
            if (row_pos >= h || col_pos >= w) return;
            x = col_pos;
            // row 0 releases nothing, later rows release the pixel above
            if (row_pos >= 1) begin
                v.edge_res  = judge_pixel(x, row_pos - 1, w, 1'b1, lap);
                v.frame_end = 1'b0;
                pending_verdicts.push_back(v);
            end
            line_above[x]  = line_judged[x];
            line_judged[x] = lap;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end else begin
            // flush before the last row is complete is dropped
            if (row_pos < h || flush_pos >= w) return;
            x = flush_pos;
            v.edge_res  = judge_pixel(x, h - 1, w, 1'b0, 0);
            v.frame_end = (x + 1 == w);
            pending_verdicts.push_back(v);
            line_above[x] = line_judged[x];
            flush_pos++;
            if (flush_pos >= w) begin
                flush_pos = 0;
                col_pos   = 0;
                row_pos   = 0;
            end
        end
    endfunction

    // idle cycles before the next word or after a result word
    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------
    // driver: one word at a time from lap_words, model updated on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        int unsigned gap_left;
        t_lap_word   nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                mark_edges(s_axis_tuser, s_axis_tdata);
                words_outstanding--;
            end
            // only touch the bus once the current word is gone
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (lap_words.size() != 0) begin
                    nxt = lap_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.op;
                    s_axis_tdata  <= nxt.lap_value;
                    gap_left = draw_wait();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compare every result word with the oldest verdict, random stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        int unsigned   stall_left;
        t_edge_verdict want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("edge_res: no word expected, actual %0d", m_axis_tdata[0]);
                    mismatch_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want.edge_res) begin
                        $error("edge_res: expected %0d, actual %0d",
                               want.edge_res, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, m_axis_tlast);
                        mismatch_count++;
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_word(logic op, logic [LAP_BITS-1:0] lap);
        t_lap_word wd;
        wd.op        = op;
        wd.lap_value = lap;
        words_outstanding++;
        lap_words.push_back(wd);
    endtask

    // zeros often, small values for threshold play, extremes, full range
    function automatic logic [LAP_BITS-1:0] rand_lap();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return LAP_BITS'($urandom_range(1, 60));
            3:       return -LAP_BITS'($urandom_range(1, 60));
            4:       return 16'h8000;
            5:       return 16'h7fff;
            default: return LAP_BITS'($urandom);
        endcase
    endfunction

    // rest of a frame from a given position, with dropped words mixed in;
    // a nonzero cut ends the frame early after that many counted words
    task automatic queue_frame(int unsigned w, int unsigned h, int unsigned pix_from,
                               int unsigned flush_from, int unsigned cut);
        int unsigned sent;
        sent = 0;
        for (int unsigned p = pix_from; p < w * h; p++) begin
            // flush arriving too early
            if ($urandom_range(0, 15) == 0) push_word(lzce_pkg::OP_FLUSH, LAP_BITS'($urandom));
            push_word(lzce_pkg::OP_PIXEL, rand_lap());
            random_words++;
            sent++;
            if (cut != 0 && sent >= cut) return;
        end
        for (int unsigned f = flush_from; f < w; f++) begin
            // pixel while the last row waits for its flush
            if ($urandom_range(0, 7) == 0) push_word(lzce_pkg::OP_PIXEL, rand_lap());
            push_word(lzce_pkg::OP_FLUSH, LAP_BITS'($urandom));
            random_words++;
            sent++;
            if (cut != 0 && sent >= cut) return;
        end
    endtask

    // all words taken, all verdicts met, then room for dropped words in flight
    task automatic wait_idle();
        while (words_outstanding != 0 || pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lzce_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [lzce_pkg::CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            lzce_pkg::REG_IMAGE_WIDTH: begin
                width_reg = val[lzce_pkg::WIDTH_BITS-1:0];
                col_pos   = 0;
                row_pos   = 0;
                flush_pos = 0;
            end
            lzce_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = val[lzce_pkg::HEIGHT_BITS-1:0];
                col_pos    = 0;
                row_pos    = 0;
                flush_pos  = 0;
            end
            lzce_pkg::REG_SLOPE_THRESHOLD: begin
                thresh_reg = val[lzce_pkg::THRESH_BITS-1:0];
            end
            default: ;
        endcase
    endtask

    // size writes restart the frame; the pause covers the window reload
    task automatic set_regs(bit sizes_too, int unsigned w_raw, int unsigned h_raw,
                            int unsigned t_raw);
        if (sizes_too) begin
            write_reg(lzce_pkg::REG_IMAGE_WIDTH, lzce_pkg::CFG_DATA_BITS'(w_raw));
            write_reg(lzce_pkg::REG_IMAGE_HEIGHT, lzce_pkg::CFG_DATA_BITS'(h_raw));
        end
        write_reg(lzce_pkg::REG_SLOPE_THRESHOLD, lzce_pkg::CFG_DATA_BITS'(t_raw));
        i_cfg_we <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int          directed_lap [12];
        bit          thresh_only;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned t_raw;
        int unsigned w;
        int unsigned h;
        int unsigned frames;
        int unsigned cut;
        int unsigned pix_from;
        int unsigned flush_from;

        directed_lap = '{-32768, 32767, 0, -1,
                         0, 1, -32768, 0,
                         32767, 0, 0, -1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 4x3 frame, extremes, zero pixels inside and on the border,
        // early flush, pixel past the last row, flush of the next frame
        set_regs(1'b1, 4, 3, 0);
        push_word(lzce_pkg::OP_FLUSH, '0);
        foreach (directed_lap[i]) push_word(lzce_pkg::OP_PIXEL, LAP_BITS'(directed_lap[i]));
        push_word(lzce_pkg::OP_PIXEL, LAP_BITS'(5));
        repeat (4) push_word(lzce_pkg::OP_FLUSH, 16'hffff);
        push_word(lzce_pkg::OP_FLUSH, '0);
        wait_idle();

        // directed: zero width and height act as a single pixel, top threshold
        set_regs(1'b1, 0, 0, 65535);
        push_word(lzce_pkg::OP_PIXEL, 16'h8000);
        push_word(lzce_pkg::OP_FLUSH, '0);
        wait_idle();

        // random phases: mostly small frames, some cut short, some carried
        // on across a threshold-only change
        while (random_words < 200) begin
            steady      = ($urandom_range(0, 4) == 0);
            thresh_only = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       t_raw = 0;
                1:       t_raw = 65535;
                2:       t_raw = $urandom_range(0, 120);
                default: t_raw = $urandom_range(0, 65535);
            endcase
            if (thresh_only) begin
                set_regs(1'b0, 0, 0, t_raw);
            end else begin
                case ($urandom_range(0, 5))
                    0:       w_raw = 0;
                    1:       w_raw = 1;
                    2:       w_raw = 2;
                    default: w_raw = $urandom_range(3, 9);
                endcase
                case ($urandom_range(0, 4))
                    0:       h_raw = 0;
                    1:       h_raw = 1;
                    default: h_raw = $urandom_range(2, 6);
                endcase
                set_regs(1'b1, w_raw, h_raw, t_raw);
            end
            w = eff_w();
            h = eff_h();
            // the block is idle here, so the model shows where the frame stands
            pix_from   = (row_pos >= h) ? w * h : row_pos * w + col_pos;
            flush_from = flush_pos;
            frames     = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                cut = (f == frames - 1 && $urandom_range(0, 4) == 0) ?
                      $urandom_range(1, w * h + w) : 0;
                queue_frame(w, h, pix_from, flush_from, cut);
                pix_from   = 0;
                flush_from = 0;
            end
            wait_idle();
        end

        // widest row: width register above the line store size, one full row
        // and the first flush ticks after it
        steady = 1'b0;
        set_regs(1'b1, 2047, 1, $urandom_range(0, 120));
        queue_frame(eff_w(), eff_h(), 0, 0, eff_w() + 8);
        wait_idle();

        // tallest setting: height register above the row limit, two columns;
        // the frame start runs and flush ticks stay dropped
        set_regs(1'b1, 2, 8191, $urandom_range(0, 120));
        queue_frame(eff_w(), eff_h(), 0, 0, 40);
        push_word(lzce_pkg::OP_FLUSH, '0);
        push_word(lzce_pkg::OP_FLUSH, '0);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/lzce_pkg.sv
hdl/lzce_line_buf.sv
hdl/lzce_judge.sv
hdl/laplacian_zero_crossing_edges.sv
tb/sv/laplacian_zero_crossing_edges_tb.sv
